[hw/rtl/wgd_pkg.sv]
// Package for the waveform generator DAC unit: sizes, register indexes, state codes
// and the elaboration-time builder for the Q1.15 sine table.
// No dependencies.
package wgd_pkg;

    // Phase accumulator: one waveform period is 10^7 microsecond-times-0.1 Hz units.
    localparam int PHASE_PERIOD = 10_000_000;
    localparam int PH_W         = 24;

    // Payload and register field widths.
    localparam int ELAPSED_W  = 10;
    localparam int FREQ_W     = 7;
    localparam int STEP_W     = ELAPSED_W + FREQ_W;
    localparam int LEVEL_W    = 12;
    localparam int DUTY_W     = 7;
    localparam int CTRL_W     = 4;
    localparam int CODE_W     = 12;
    localparam int WORD_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Sine table and DAC range.
    localparam int SINE_ENTRIES = 1024;
    localparam int DAC_BITS     = 12;
    localparam int SAMPLE_W     = 16;
    localparam int IDX_W        = $clog2(SINE_ENTRIES);
    localparam int CODE_MAX     = (1 << DAC_BITS) - 1;

    // Division by PHASE_PERIOD: a reciprocal product gives a quotient that is exact or one
    // short, a remainder step tells which, and a final step corrects it.
    localparam int QW          = (LEVEL_W > IDX_W) ? LEVEL_W : IDX_W;
    localparam int DVW         = PH_W + QW;
    localparam int RECIP_SHIFT = DVW;
    localparam longint unsigned RECIP_MULT = (64'd1 << RECIP_SHIFT) / PHASE_PERIOD;
    localparam int RCW         = RECIP_SHIFT + QW;
    localparam int Q_STEPS     = 3;
    localparam int CNT_W       = $clog2(Q_STEPS);

    // Signed level arithmetic and the sine product.
    localparam int LVL_W  = ((DAC_BITS > 14) ? DAC_BITS : 14) + 2;
    localparam int PROD_W = LEVEL_W + SAMPLE_W;
    localparam int SQ_W   = 32;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_SAW    = 2'd1,
        MODE_SINE   = 2'd2,
        MODE_SQUARE = 2'd3
    } wave_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WAVE_MODE    = 3'd0,
        CFG_FREQ_TENTHS  = 3'd1,
        CFG_HIGH_LEVEL   = 3'd2,
        CFG_LOW_LEVEL    = 3'd3,
        CFG_DUTY_PERCENT = 3'd4,
        CFG_SLOPE_DOWN   = 3'd5,
        CFG_DAC_CONTROL  = 3'd6
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADVANCE,
        ST_LOAD,
        ST_DIVIDE,
        ST_READ,
        ST_MULT,
        ST_LEVEL
    } state_t;

    typedef logic [SAMPLE_W-1:0] sine_rom_t [SINE_ENTRIES];

    // Unsigned long division by shift and subtract, for building the table.
    function automatic longint unsigned div_shift_sub(input longint unsigned num,
                                                      input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem_v;
        quo   = 0;
        rem_v = 0;
        for (int b = 63; b >= 0; b--) begin
            rem_v = (rem_v << 1) | ((num >> b) & 64'd1);
            if (rem_v >= den) begin
                rem_v = rem_v - den;
                quo   = quo | (64'd1 << b);
            end
        end
        return quo;
    endfunction

    // sin(pi/2 * num / SINE_ENTRIES) in unsigned Q1.15, from an odd Taylor series in Q30.
    function automatic logic [SAMPLE_W-1:0] quarter_sine(input longint unsigned num);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned den;
        longint          sum;
        longint          s15;
        int              k;
        x    = (HALF_PI_Q30 * num) / SINE_ENTRIES;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (k = 1; k <= 8; k++) begin
            den  = longint'(unsigned'((2 * k) * (2 * k + 1)));
            term = div_shift_sub((term * x2) >> 30, den);
            if ((k & 1) != 0) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        s15 = (sum * 32767 + (longint'(1) << 29)) >>> 30;
        if (s15 > 32767) begin
            s15 = 32767;
        end
        return SAMPLE_W'(s15);
    endfunction

    // Full-period table built from quarter-wave symmetry.
    function automatic sine_rom_t sine_rom_init();
        sine_rom_t             rom;
        int unsigned           pos;
        int unsigned           quad;
        int unsigned           rem_v;
        logic [SAMPLE_W-1:0]   mag;
        logic [SAMPLE_W:0]     neg;
        for (int i = 0; i < SINE_ENTRIES; i++) begin
            pos   = 4 * i;
            quad  = pos / SINE_ENTRIES;
            rem_v = pos % SINE_ENTRIES;
            if ((quad & 1) != 0) begin
                mag = quarter_sine(longint'(SINE_ENTRIES - rem_v));
            end else begin
                mag = quarter_sine(longint'(rem_v));
            end
            neg = (SAMPLE_W + 1)'(1 << SAMPLE_W) - {1'b0, mag};
            rom[i] = (quad >= 2) ? neg[SAMPLE_W-1:0] : mag;
        end
        return rom;
    endfunction

endpackage

[hw/rtl/waveform_generator_dac_unit.sv]
// Waveform generator DAC unit: phase accumulator, shared division by the phase
// period, sine ROM and level computation with saturation.
// Depends on wgd_pkg.
//
// Usage: each transfer on the s_ channel carries s_elapsed_us, the microseconds
// since the previous sample. The block advances its phase by elapsed_us times
// freq_tenths modulo 10^7 and, unless the mode is off, delivers one transfer on
// the m_ channel with the 12-bit DAC code and the 16-bit DAC word (control nibble
// on top). Registers are written through the cfg_ channel while the block is idle;
// cfg_ready is always high and unknown indexes are ignored.
// Each accepted item passes through the states advance, load, the division by the
// phase period (reciprocal estimate, remainder and correction), the registered sine
// ROM read and product, and level; square skips the division, sawtooth skips the ROM
// read and product, and mode off returns to idle after advance. A new item is taken
// only after the previous result has been loaded and the sequencer is back in idle.
// A finished result sits in the output register; the next item is accepted while
// it waits, and only the final load stalls while the receiver holds m_ready low.
// Reset is synchronous and active low: it returns the phase to zero, the registers
// to their default values and empties the output register. No fill pass is needed.
module waveform_generator_dac_unit
    import wgd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [ELAPSED_W-1:0]  s_elapsed_us,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CODE_W-1:0]     m_dac_code,
    output logic [WORD_W-1:0]     m_dac_word,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // The sine table is a read-only memory with a registered read.
    localparam sine_rom_t SINE_ROM = sine_rom_init();

    localparam logic [PH_W:0] PERIOD_EXT = (PH_W + 1)'(PHASE_PERIOD);
    localparam logic signed [LVL_W-1:0] CODE_MAX_S = LVL_W'(CODE_MAX);

    // Configuration registers.
    wave_mode_t          wave_mode_reg;
    logic [FREQ_W-1:0]   freq_tenths_reg;
    logic [LEVEL_W-1:0]  high_level_reg;
    logic [LEVEL_W-1:0]  low_level_reg;
    logic [DUTY_W-1:0]   duty_percent_reg;
    logic                slope_down_reg;
    logic [CTRL_W-1:0]   dac_control_reg;

    // Sequencer and datapath.
    state_t                      state_reg;
    state_t                      state_next;
    logic                        out_load;
    logic [STEP_W-1:0]           step_reg;
    logic [PH_W-1:0]             phase_reg;
    logic [PH_W-1:0]             phase_next;
    logic [PH_W:0]               phase_sum;
    logic signed [LEVEL_W-1:0]   amp_reg;
    logic signed [LEVEL_W-1:0]   amp_next;
    logic signed [LEVEL_W:0]     level_diff;
    logic signed [LEVEL_W:0]     amp_full;
    logic [LEVEL_W-1:0]          amp_abs;
    logic [LEVEL_W-1:0]          two_amp;
    logic [DVW-1:0]              dividend;
    logic [DVW-1:0]              div_reg;
    logic [RCW-1:0]              recip_next;
    logic [DVW-1:0]              rem_wide;
    logic [PH_W:0]               rem_reg;
    logic [QW-1:0]               quot_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        sq_high_reg;
    logic [SAMPLE_W-1:0]         sample_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [PROD_W-1:0]    prod_bias;
    logic signed [PROD_W-1:0]    prod_adj;
    logic signed [LVL_W-1:0]     sine_term;
    logic signed [LVL_W-1:0]     ramp_s;
    logic signed [LVL_W-1:0]     low_s;
    logic signed [LVL_W-1:0]     high_s;
    logic signed [LVL_W-1:0]     amp_s;
    logic signed [LVL_W-1:0]     level;
    logic [LVL_W-1:0]            level_sat;
    logic                        m_valid_reg;
    logic [CODE_W-1:0]           m_code_reg;
    logic [WORD_W-1:0]           m_word_reg;

    assign s_ready    = (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign m_valid    = m_valid_reg;
    assign m_dac_code = m_code_reg;
    assign m_dac_word = m_word_reg;

    // Register writes. An index outside the list leaves every register unchanged.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_mode_reg    <= MODE_OFF;
            freq_tenths_reg  <= FREQ_W'(50);
            high_level_reg   <= LEVEL_W'(4095);
            low_level_reg    <= '0;
            duty_percent_reg <= DUTY_W'(50);
            slope_down_reg   <= 1'b0;
            dac_control_reg  <= CTRL_W'(3);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index_t'(cfg_index))
                CFG_WAVE_MODE:    wave_mode_reg    <= wave_mode_t'(cfg_data[1:0]);
                CFG_FREQ_TENTHS:  freq_tenths_reg  <= cfg_data[FREQ_W-1:0];
                CFG_HIGH_LEVEL:   high_level_reg   <= cfg_data[LEVEL_W-1:0];
                CFG_LOW_LEVEL:    low_level_reg    <= cfg_data[LEVEL_W-1:0];
                CFG_DUTY_PERCENT: duty_percent_reg <= cfg_data[DUTY_W-1:0];
                CFG_SLOPE_DOWN:   slope_down_reg   <= cfg_data[0];
                CFG_DAC_CONTROL:  dac_control_reg  <= cfg_data[CTRL_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer state register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state. The output register is loaded only once it is empty or being drained.
    always_comb begin
        state_next = state_reg;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_ADVANCE;
                end
            end
            ST_ADVANCE: begin
                state_next = (wave_mode_reg == MODE_OFF) ? ST_IDLE : ST_LOAD;
            end
            ST_LOAD: begin
                state_next = (wave_mode_reg == MODE_SQUARE) ? ST_LEVEL : ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (cnt_reg == CNT_W'(Q_STEPS - 1)) begin
                    state_next = (wave_mode_reg == MODE_SINE) ? ST_READ : ST_LEVEL;
                end
            end
            ST_READ: begin
                state_next = ST_MULT;
            end
            ST_MULT: begin
                state_next = ST_LEVEL;
            end
            ST_LEVEL: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Phase advance with a single wrap, and the half swing, truncated toward zero.
    always_comb begin
        phase_sum  = {1'b0, phase_reg} + (PH_W + 1)'(step_reg);
        phase_next = (phase_sum >= PERIOD_EXT) ? PH_W'(phase_sum - PERIOD_EXT)
                                               : phase_sum[PH_W-1:0];
        level_diff = signed'({1'b0, high_level_reg}) - signed'({1'b0, low_level_reg});
        amp_full   = (level_diff + (LEVEL_W + 1)'(level_diff < 0)) >>> 1;
        amp_next   = amp_full[LEVEL_W-1:0];
    end

    // Dividend for the divider: 2*|amp|*phase for the ramp, phase*entries for the index.
    always_comb begin
        amp_abs  = amp_reg[LEVEL_W-1] ? LEVEL_W'(-amp_reg) : LEVEL_W'(amp_reg);
        two_amp  = {amp_abs[LEVEL_W-2:0], 1'b0};
        if (wave_mode_reg == MODE_SINE) begin
            dividend = DVW'(phase_reg) * DVW'(SINE_ENTRIES);
        end else begin
            dividend = DVW'(two_amp) * DVW'(phase_reg);
        end
    end

    // Division by the phase period. The reciprocal is rounded down, so the estimate is
    // exact or one short; the remainder left over from the estimate decides the last step.
    always_comb begin
        recip_next = RCW'(div_reg) * RCW'(RECIP_MULT);
        rem_wide   = div_reg - DVW'(quot_reg) * DVW'(PHASE_PERIOD);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
        end else if (state_reg == ST_ADVANCE) begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            step_reg <= STEP_W'(s_elapsed_us) * STEP_W'(freq_tenths_reg);
        end
        if (state_reg == ST_ADVANCE) begin
            amp_reg <= amp_next;
        end
        if (state_reg == ST_LOAD) begin
            div_reg     <= dividend;
            cnt_reg     <= '0;
            sq_high_reg <= (SQ_W'(phase_reg) * SQ_W'(100))
                         < (SQ_W'(duty_percent_reg) * SQ_W'(PHASE_PERIOD));
        end
        if (state_reg == ST_DIVIDE) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            case (cnt_reg)
                CNT_W'(0): begin
                    quot_reg <= recip_next[RCW-1:RECIP_SHIFT];
                end
                CNT_W'(1): begin
                    rem_reg <= rem_wide[PH_W:0];
                end
                CNT_W'(2): begin
                    if (rem_reg >= PERIOD_EXT) begin
                        quot_reg <= quot_reg + QW'(1);
                    end
                end
                default: ;
            endcase
        end
        if (state_reg == ST_READ) begin
            sample_reg <= SINE_ROM[quot_reg[IDX_W-1:0]];
        end
        if (state_reg == ST_MULT) begin
            prod_reg <= PROD_W'(amp_reg) * PROD_W'($signed(sample_reg));
        end
    end

    // Level: low + amp + wave term for sawtooth and sine, high or low for square, then saturation to the DAC range.
    always_comb begin
        prod_bias = '0;
        if (prod_reg < 0) begin
            prod_bias = PROD_W'(32'sd32767);
        end
        prod_adj  = prod_reg + prod_bias;
        sine_term = LVL_W'(prod_adj >>> (SAMPLE_W - 1));

        ramp_s = signed'(LVL_W'(quot_reg));
        if (amp_reg[LEVEL_W-1]) begin
            ramp_s = -ramp_s;
        end

        low_s  = signed'(LVL_W'(low_level_reg));
        high_s = signed'(LVL_W'(high_level_reg));
        amp_s  = LVL_W'(amp_reg);

        case (wave_mode_reg)
            MODE_SAW: begin
                if (slope_down_reg) begin
                    level = low_s + amp_s + (amp_s - ramp_s);
                end else begin
                    level = low_s + amp_s + (ramp_s - amp_s);
                end
            end
            MODE_SINE:   level = low_s + amp_s + sine_term;
            MODE_SQUARE: level = sq_high_reg ? high_s : low_s;
            default:     level = low_s;
        endcase

        if (level < 0) begin
            level_sat = '0;
        end else if (level > CODE_MAX_S) begin
            level_sat = CODE_MAX_S;
        end else begin
            level_sat = level;
        end
    end

    // Output register: holds a result until the receiver takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_code_reg <= level_sat[CODE_W-1:0];
            m_word_reg <= {dac_control_reg, level_sat[CODE_W-1:0]};
        end
    end

    // A new result only appears right after the level step.
    a_result_from_level: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_LEVEL)
        else $error("result appeared without a level step");

    // The phase never leaves one period.
    a_phase_in_period: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg < PH_W'(PHASE_PERIOD))
        else $error("phase outside one period");

    // The divider yields a table index inside the sine table.
    a_index_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_READ |-> {1'b0, quot_reg} < (QW + 1)'(SINE_ENTRIES))
        else $error("sine index out of range");

    // The divider step count stays within its iterations.
    a_divide_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIVIDE |-> cnt_reg < CNT_W'(Q_STEPS))
        else $error("divider ran past its last step");

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// Self-checking bench for waveform_generator_dac_unit: directed and random sample ticks,
// with register programming between phases and a scoreboard that predicts every DAC sample.
// Depends on wgd_pkg and the unit's RTL.
module testbench;
    import wgd_pkg::*;

    // One waveform period in microsecond x 0.1 Hz units, and the sine table depth.
    localparam longint PHASE_WRAP = 64'sd10_000_000;
    localparam int SINE_DEPTH = 1024;
    // pi/2 in Q30, the seed of the quarter-wave series.
    localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
    localparam longint DAC_FULL_SCALE = 64'sd4095;
    // The sine path takes the longest after acceptance; allow some margin
    // before touching registers or declaring the run over.
    localparam int QUIET_CYCLES = 16;
    localparam int RANDOM_TICKS = 1550;
    // An index beyond the register file; writes to it must leave everything unchanged.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct {
        logic [CODE_W-1:0] code;
        logic [WORD_W-1:0] word;
    } dac_sample_t;

    typedef struct {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } reg_write_t;

    // Receiver behaviors: always ready, coin flip, mostly stalled, long blocked stretches.
    typedef enum int {
        PACE_STEADY,
        PACE_COIN,
        PACE_SPARSE,
        PACE_BLOCKED
    } pace_t;

    // Scoreboard: mirrors the register file and phase accumulator, computes the DAC sample
    // for each accepted tick and compares delivered samples against them in order.
    class dac_tracker;
        wave_mode_t         mode;
        logic [FREQ_W-1:0]  freq;
        logic [LEVEL_W-1:0] high_lvl;
        logic [LEVEL_W-1:0] low_lvl;
        logic [DUTY_W-1:0]  duty;
        logic               slope_dn;
        logic [CTRL_W-1:0]  ctrl;
        longint             phase;
        logic [15:0]        sine_rom [SINE_DEPTH];
        dac_sample_t        pending_samples[$];
        int unsigned        errors;
        int unsigned        ticks;
        int unsigned        silent_ticks;
        int unsigned        checked;
        int unsigned        reg_writes;
        int unsigned        per_mode[4];

        function new();
            int unsigned pos;
            int unsigned quad;
            int unsigned offs;
            logic [15:0] mag;
            // Full period from the first quadrant: mirror in odd quadrants, negate in the
            // second half.
            for (int i = 0; i < SINE_DEPTH; i++) begin
                pos  = 4 * i;
                quad = pos / SINE_DEPTH;
                offs = pos % SINE_DEPTH;
                mag  = quarter_wave((quad % 2 == 1) ? SINE_DEPTH - offs : offs);
                sine_rom[i] = (quad >= 2) ? 16'h0 - mag : mag;
            end
            mode     = MODE_OFF;
            freq     = 50;
            high_lvl = 4095;
            low_lvl  = 0;
            duty     = 50;
            slope_dn = 1'b0;
            ctrl     = 4'd3;
            phase    = 0;
            errors   = 0;
            ticks    = 0;
            silent_ticks = 0;
            checked  = 0;
            reg_writes = 0;
            per_mode = '{default: 0};
        endfunction

        // sin(pi/2 * num / depth) in unsigned Q1.15 via the odd series up to x^17 in Q30.
        function logic [15:0] quarter_wave(int unsigned num);
            longint unsigned ang;
            longint unsigned ang_sq;
            longint unsigned term;
            longint unsigned den;
            longint          acc;
            longint          q15;
            ang    = (QUARTER_TURN_Q30 * num) / SINE_DEPTH;
            ang_sq = (ang * ang) >> 30;
            term   = ang;
            acc    = longint'(ang);
            for (int k = 1; k <= 8; k++) begin
                den  = 2 * k * (2 * k + 1);
                term = ((term * ang_sq) >> 30) / den;
                if (k % 2 == 1) begin
                    acc = acc - longint'(term);
                end else begin
                    acc = acc + longint'(term);
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            q15 = (acc * 32767 + (longint'(1) << 29)) >>> 30;
            if (q15 > 32767) begin
                q15 = 32767;
            end
            return 16'(q15);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            reg_writes++;
            case (index)
                CFG_WAVE_MODE:    mode     = wave_mode_t'(data[1:0]);
                CFG_FREQ_TENTHS:  freq     = data[FREQ_W-1:0];
                CFG_HIGH_LEVEL:   high_lvl = data[LEVEL_W-1:0];
                CFG_LOW_LEVEL:    low_lvl  = data[LEVEL_W-1:0];
                CFG_DUTY_PERCENT: duty     = data[DUTY_W-1:0];
                CFG_SLOPE_DOWN:   slope_dn = data[0];
                CFG_DAC_CONTROL:  ctrl     = data[CTRL_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance the phase for one accepted tick and queue the sample it produces, if any.
        function void log_tick(logic [ELAPSED_W-1:0] us);
            longint      lo;
            longint      amp;
            longint      lvl;
            longint      ramp;
            longint      smp;
            longint      idx;
            dac_sample_t s;
            ticks++;
            phase = phase + longint'(us) * longint'(freq);
            if (phase >= PHASE_WRAP) begin
                phase = phase - PHASE_WRAP;
            end
            if (mode == MODE_OFF) begin
                silent_ticks++;
                return;
            end
            lo  = longint'(low_lvl);
            // Signed half swing; negative when the high level sits below the low one.
            amp = (longint'(high_lvl) - lo) / 2;
            lvl = lo;
            case (mode)
                MODE_SAW: begin
                    ramp = (2 * amp * phase) / PHASE_WRAP;
                    if (slope_dn) begin
                        lvl = lo + amp + (amp - ramp);
                    end else begin
                        lvl = lo + amp + (ramp - amp);
                    end
                end
                MODE_SINE: begin
                    idx = (phase * SINE_DEPTH) / PHASE_WRAP;
                    smp = longint'(signed'(sine_rom[idx]));
                    lvl = lo + amp + (amp * smp) / 32768;
                end
                MODE_SQUARE: begin
                    if (phase * 100 < longint'(duty) * PHASE_WRAP) begin
                        lvl = longint'(high_lvl);
                    end
                end
                default: ;
            endcase
            if (lvl < 0) begin
                lvl = 0;
            end
            if (lvl > DAC_FULL_SCALE) begin
                lvl = DAC_FULL_SCALE;
            end
            s.code = CODE_W'(lvl);
            s.word = {ctrl, s.code};
            per_mode[int'(mode)]++;
            pending_samples.push_back(s);
        endfunction

        function void match_sample(logic [CODE_W-1:0] code, logic [WORD_W-1:0] word);
            dac_sample_t want;
            if (pending_samples.size() == 0) begin
                $error("sample dac_code %0d dac_word 0x%04h arrived with none expected",
                       code, word);
                errors++;
                return;
            end
            want = pending_samples.pop_front();
            checked++;
            if (code !== want.code) begin
                $error("dac_code mismatch: expected %0d, actual %0d", want.code, code);
                errors++;
            end
            if (word !== want.word) begin
                $error("dac_word mismatch: expected 0x%04h, actual 0x%04h", want.word, word);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic [ELAPSED_W-1:0]  s_elapsed_us = '0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic [CODE_W-1:0]     m_dac_code;
    logic [WORD_W-1:0]     m_dac_word;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    dac_tracker  tracker;
    int          burst_left = 0;
    bit          gaps_on    = 1'b1;
    pace_t       pace       = PACE_STEADY;
    int          pace_left  = 0;
    int unsigned phases     = 0;

    waveform_generator_dac_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_elapsed_us (s_elapsed_us),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_dac_code   (m_dac_code),
        .m_dac_word   (m_dac_word),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 aclk = ~aclk;

    // Receiver back-pressure: a new pacing is picked each time the pacing counter runs out,
    // so results meet stalls of each kind and some stretches run with m_ready held high.
    always @(posedge aclk) begin
        if (pace_left == 0) begin
            pace      = pace_t'($urandom_range(0, 3));
            pace_left = $urandom_range(50, 300);
        end else begin
            pace_left--;
        end
        case (pace)
            PACE_STEADY:  m_ready <= 1'b1;
            PACE_COIN:    m_ready <= 1'($urandom_range(0, 1));
            PACE_SPARSE:  m_ready <= ($urandom_range(0, 3) == 0);
            PACE_BLOCKED: m_ready <= ((pace_left % 40) < 6);
            default:      m_ready <= 1'b1;
        endcase
    end

    // Output monitor. Signals are read before this edge's updates take effect, so the
    // transfer seen here is exactly the one the unit completed at this edge.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tracker.match_sample(m_dac_code, m_dac_word);
        end
    end

    // Register data with random bits above the field, which the unit must ignore.
    function automatic logic [CFG_DATA_W-1:0] with_noise(input int unsigned value,
                                                         input int width);
        logic [CFG_DATA_W-1:0] keep;
        keep = CFG_DATA_W'((1 << width) - 1);
        return (CFG_DATA_W'($urandom) & ~keep) | (CFG_DATA_W'(value) & keep);
    endfunction

    // A level code that hits both rails now and then.
    function automatic int unsigned pick_level();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 4095;
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    // Present one tick and hold it until the transfer happens. Ticks go out in bursts;
    // after each burst the sender may drop valid for a random gap.
    task automatic send_tick(input logic [ELAPSED_W-1:0] us);
        s_valid      <= 1'b1;
        s_elapsed_us <= us;
        do @(posedge aclk); while (!s_ready);
        tracker.log_tick(us);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            if (gaps_on) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    endtask

    task automatic send_each(input int unsigned ticks_in[$]);
        foreach (ticks_in[i]) begin
            send_tick(ELAPSED_W'(ticks_in[i]));
        end
    endtask

    // Drain: stop sending, wait for every expected sample, then let a mode-off tick that
    // may still be in flight finish before anything else happens.
    task automatic settle();
        s_valid <= 1'b0;
        while (tracker.pending_samples.size() != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    // Program the whole register file once the unit is idle, back to back.
    task automatic set_regs(input wave_mode_t mode, input int unsigned freq,
                            input int unsigned hi, input int unsigned lo,
                            input int unsigned duty, input int unsigned slope,
                            input int unsigned ctrl, input bit poke_unused);
        reg_write_t plan[$];
        settle();
        phases++;
        if (poke_unused) begin
            plan.push_back('{CFG_UNUSED, CFG_DATA_W'($urandom)});
        end
        plan.push_back('{CFG_WAVE_MODE,    with_noise(mode, $bits(wave_mode_t))});
        plan.push_back('{CFG_FREQ_TENTHS,  with_noise(freq, FREQ_W)});
        plan.push_back('{CFG_HIGH_LEVEL,   with_noise(hi, LEVEL_W)});
        plan.push_back('{CFG_LOW_LEVEL,    with_noise(lo, LEVEL_W)});
        plan.push_back('{CFG_DUTY_PERCENT, with_noise(duty, DUTY_W)});
        plan.push_back('{CFG_SLOPE_DOWN,   with_noise(slope, 1)});
        plan.push_back('{CFG_DAC_CONTROL,  with_noise(ctrl, CTRL_W)});
        foreach (plan[i]) begin
            cfg_valid <= 1'b1;
            cfg_index <= plan[i].index;
            cfg_data  <= plan[i].data;
            do @(posedge aclk); while (!cfg_ready);
            tracker.write_reg(plan[i].index, plan[i].data);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int unsigned          r;
        int unsigned          n;
        int unsigned          freq;
        int unsigned          duty;
        int unsigned          random_sent;
        wave_mode_t           mode_pick;
        logic [ELAPSED_W-1:0] us;

        tracker = new();
        random_sent = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings leave the output off: the phase moves, nothing comes out.
        // The zero tick must not move the phase at all.
        send_each('{0, 1023});
        // Rising ramp at a frequency above 100.
        set_regs(MODE_SAW, 127, 4095, 0, 50, 0, 15, 1'b0);
        send_each('{1023, 0, 1, 1023});
        // Falling ramp, control nibble cleared.
        set_regs(MODE_SAW, 100, 4095, 0, 50, 1, 0, 1'b0);
        send_each('{1023, 512});
        set_regs(MODE_SINE, 100, 4095, 0, 50, 0, 5, 1'b0);
        send_each('{1023, 1023, 0, 700});
        // High level below the low one: the swing is negative and the waves invert.
        set_regs(MODE_SINE, 127, 0, 4095, 50, 0, 10, 1'b0);
        send_each('{1023, 1023});
        set_regs(MODE_SAW, 127, 0, 4095, 50, 0, 10, 1'b0);
        send_each('{1023, 333});
        // Square wave: zero duty stays low, duty above 100 stays high, then a mid duty.
        set_regs(MODE_SQUARE, 100, 4095, 0, 0, 0, 3, 1'b0);
        send_each('{1023});
        set_regs(MODE_SQUARE, 100, 4095, 0, 127, 0, 3, 1'b0);
        send_each('{1023});
        set_regs(MODE_SQUARE, 100, 3000, 1000, 50, 0, 9, 1'b0);
        send_each('{1023, 1023});
        // A write to an unused index must be dropped.
        set_regs(MODE_SQUARE, 100, 3000, 1000, 100, 0, 9, 1'b1);
        send_each('{1});

        // Random phases: fresh settings each time, mostly with a waveform running, and
        // a quarter of the phases with the sender never pausing.
        while (random_sent < RANDOM_TICKS) begin
            r = $urandom_range(0, 9);
            mode_pick = (r == 0) ? MODE_OFF :
                        (r < 4)  ? MODE_SAW :
                        (r < 7)  ? MODE_SINE : MODE_SQUARE;
            case ($urandom_range(0, 7))
                0:       freq = 0;
                1:       freq = 100;
                2:       freq = 127;
                default: freq = $urandom_range(1, 127);
            endcase
            case ($urandom_range(0, 7))
                0:       duty = 0;
                1:       duty = 100;
                2:       duty = 127;
                default: duty = $urandom_range(0, 127);
            endcase
            set_regs(mode_pick, freq, pick_level(), pick_level(), duty,
                     $urandom_range(0, 1), $urandom_range(0, 15),
                     $urandom_range(0, 3) == 0);
            gaps_on = ($urandom_range(0, 3) != 0);
            n = $urandom_range(20, 80);
            repeat (n) begin
                r = $urandom_range(0, 31);
                if (r == 0) begin
                    us = '0;
                end else if (r == 1) begin
                    us = '1;
                end else begin
                    us = ELAPSED_W'($urandom_range(1, 1023));
                end
                send_tick(us);
                random_sent++;
            end
        end

        // Everything sent: drain and give any stray sample time to show up.
        settle();
        $display("Run covered %0d ticks (%0d with the output off), %0d settings, %0d writes.",
                 tracker.ticks, tracker.silent_ticks, phases, tracker.reg_writes);
        $display("Samples checked: %0d (sawtooth %0d, sine %0d, square %0d).",
                 tracker.checked, tracker.per_mode[int'(MODE_SAW)],
                 tracker.per_mode[int'(MODE_SINE)], tracker.per_mode[int'(MODE_SQUARE)]);
        if (tracker.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog: ends the run at several times the slowest legal run even with
    // every sample held up by the longest receiver stall.
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/wgd_pkg.sv
hw/rtl/waveform_generator_dac_unit.sv
bench/testbench.sv
